// File: hdl/recent_location_table_macros.svh
// ----------------------------------------------------------------------------
// recent_location_table_macros.svh
// Assertion macros used by the recent location table RTL.
// ----------------------------------------------------------------------------
`ifndef RECENT_LOCATION_TABLE_MACROS_SVH
`define RECENT_LOCATION_TABLE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RLT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared constants and types of the recent location table.
// ----------------------------------------------------------------------------
package rlt_pkg;

   localparam int CAPACITY_DEFAULT = 10;

   localparam int OP_W   = 3;
   localparam int KEY_W  = 32;
   localparam int DATA_W = 64;
   localparam int POS_W  = 5;

   // rank reported by a position query of an absent key (-1)
   localparam logic [POS_W-1:0] POS_ABSENT = 5'h1F;

   typedef enum logic [OP_W-1:0] {
      OP_SAVE     = 3'd0,
      OP_LOOKUP   = 3'd1,
      OP_NEWEST   = 3'd2,
      OP_ERASE    = 3'd3,
      OP_POSITION = 3'd4,
      OP_EXISTS   = 3'd5
   } op_type;

endpackage

// File: hdl/recent_location_table.sv
// ----------------------------------------------------------------------------
// recent_location_table
// Fully associative table of recently saved key/data entries, ordered by
// recency, with save, lookup, newest, erase, position and exists operations.
// ----------------------------------------------------------------------------
// The table takes one word per clock while req_stall is low and returns
// exactly one result word per request, registered in the input register and
// then in the result register. All CAPACITY slots are compared against the
// key in parallel between those registers, and the rank update of every slot
// is registered together with the result, so a request sees the table as left
// by the request just before it. Rank 0 is the newest entry. A save of a new
// key into a full table evicts the entry of rank CAPACITY-1. A save of the
// newest key with unchanged data leaves the table untouched. Position
// returns -1 for an absent key. Unused op codes return a miss. After reset
// the table is empty and ready at once; no clearing pass is needed. The
// result register decouples the two sides: a stalled result holds while a
// new request still enters an empty input register.
// ----------------------------------------------------------------------------
`include "recent_location_table_macros.svh"

module recent_location_table #(
   parameter int CAPACITY = rlt_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rlt_pkg::OP_W-1:0]            req_op,
   input  logic [rlt_pkg::KEY_W-1:0]           req_key_id,
   input  logic [rlt_pkg::DATA_W-1:0]          req_entry_data,

   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [rlt_pkg::KEY_W-1:0]           rsp_found_id,
   output logic [rlt_pkg::DATA_W-1:0]          rsp_found_data,
   output logic signed [rlt_pkg::POS_W-1:0]    rsp_position
);

   // rank width and entry count width
   localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = rlt_pkg::KEY_W;
   localparam int DW = rlt_pkg::DATA_W;
   localparam int PW = rlt_pkg::POS_W;

   localparam logic [RW-1:0] RANK_OLDEST = RW'(CAPACITY - 1);
   localparam logic [CW-1:0] COUNT_FULL  = CW'(CAPACITY);

   // -------------------------------------------------------------------------
   // Input register
   // -------------------------------------------------------------------------
   logic                      s1_valid_ff, s1_valid_in;
   logic [rlt_pkg::OP_W-1:0]  s1_op_ff;
   logic [KW-1:0]             s1_key_ff;
   logic [DW-1:0]             s1_data_ff;

   logic advance;   // result register can take a new word
   logic fire;      // request in the input register executes this cycle

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign fire      = s1_valid_ff && advance;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && !req_stall) begin
         s1_op_ff   <= req_op;
         s1_key_ff  <= req_key_id;
         s1_data_ff <= req_entry_data;
      end
   end

   // -------------------------------------------------------------------------
   // Table state
   // -------------------------------------------------------------------------
   logic [CAPACITY-1:0] slot_valid_ff, slot_valid_in;
   logic [KW-1:0]       slot_key_ff  [CAPACITY];
   logic [KW-1:0]       slot_key_in  [CAPACITY];
   logic [DW-1:0]       slot_data_ff [CAPACITY];
   logic [DW-1:0]       slot_data_in [CAPACITY];
   logic [RW-1:0]       slot_rank_ff [CAPACITY];
   logic [RW-1:0]       slot_rank_in [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;

   // -------------------------------------------------------------------------
   // Parallel match
   // -------------------------------------------------------------------------
   logic [CAPACITY-1:0] key_match;    // slot holds the request key
   logic [CAPACITY-1:0] top_match;    // slot holds the newest entry
   logic [CAPACITY-1:0] old_match;    // slot holds the oldest entry when full
   logic [CAPACITY-1:0] free_first;   // lowest free slot
   logic [CAPACITY-1:0] target;       // slot written by a save
   logic [RW-1:0]       hit_rank;
   logic [DW-1:0]       hit_data;
   logic [KW-1:0]       top_key;
   logic [DW-1:0]       top_data;
   logic                any_hit, any_top, full, resave_same;
   logic [RW+PW-1:0]    rank_ext;

   always_comb begin
      hit_rank = '0;
      hit_data = '0;
      top_key  = '0;
      top_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         key_match[i] = slot_valid_ff[i] && (slot_key_ff[i] == s1_key_ff);
         top_match[i] = slot_valid_ff[i] && (slot_rank_ff[i] == '0);
         old_match[i] = slot_valid_ff[i] && (slot_rank_ff[i] == RANK_OLDEST);
         // keys are distinct, so at most one slot contributes to each mux
         hit_rank = hit_rank | (key_match[i] ? slot_rank_ff[i] : '0);
         hit_data = hit_data | (key_match[i] ? slot_data_ff[i] : '0);
         top_key  = top_key  | (top_match[i] ? slot_key_ff[i]  : '0);
         top_data = top_data | (top_match[i] ? slot_data_ff[i] : '0);
      end
   end

   assign free_first  = ~slot_valid_ff & (slot_valid_ff + CAPACITY'(1));
   assign any_hit     = |key_match;
   assign any_top     = |top_match;
   assign full        = (count_ff == COUNT_FULL);
   assign resave_same = any_hit && (hit_rank == '0) && (hit_data == s1_data_ff);
   // a present key reuses its slot; a new key goes to a free slot or evicts
   assign target      = any_hit ? key_match : (full ? old_match : free_first);
   assign rank_ext    = {{PW{1'b0}}, hit_rank};

   // -------------------------------------------------------------------------
   // Table update
   // -------------------------------------------------------------------------
   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_key_in   = slot_key_ff;
      slot_data_in  = slot_data_ff;
      slot_rank_in  = slot_rank_ff;
      count_in      = count_ff;
      if (fire) begin
         if ((s1_op_ff == rlt_pkg::OP_SAVE) && !resave_same) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (target[i]) begin
                  slot_valid_in[i] = 1'b1;
                  slot_key_in[i]   = s1_key_ff;
                  slot_data_in[i]  = s1_data_ff;
                  slot_rank_in[i]  = '0;
               end else if (slot_valid_ff[i] &&
                            (!any_hit || (slot_rank_ff[i] < hit_rank))) begin
                  slot_rank_in[i] = slot_rank_ff[i] + RW'(1);
               end
            end
            if (!any_hit && !full) begin
               count_in = count_ff + CW'(1);
            end
         end else if ((s1_op_ff == rlt_pkg::OP_ERASE) && any_hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (key_match[i]) begin
                  slot_valid_in[i] = 1'b0;
               end else if (slot_valid_ff[i] && (slot_rank_ff[i] > hit_rank)) begin
                  slot_rank_in[i] = slot_rank_ff[i] - RW'(1);
               end
            end
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
      end
      slot_key_ff  <= slot_key_in;
      slot_data_ff <= slot_data_in;
      slot_rank_ff <= slot_rank_in;
   end

   // -------------------------------------------------------------------------
   // Result register
   // -------------------------------------------------------------------------
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [KW-1:0]        rsp_id_ff, rsp_id_in;
   logic [DW-1:0]        rsp_data_ff, rsp_data_in;
   logic [PW-1:0]        rsp_pos_ff, rsp_pos_in;

   always_comb begin
      rsp_hit_in  = 1'b0;
      rsp_id_in   = s1_key_ff;
      rsp_data_in = '0;
      rsp_pos_in  = '0;
      unique case (s1_op_ff)
         rlt_pkg::OP_SAVE: begin
            rsp_hit_in = 1'b1;
         end
         rlt_pkg::OP_LOOKUP: begin
            rsp_hit_in  = any_hit;
            rsp_data_in = hit_data;
         end
         rlt_pkg::OP_NEWEST: begin
            rsp_hit_in = any_top;
            if (any_top) begin
               rsp_id_in   = top_key;
               rsp_data_in = top_data;
            end
         end
         rlt_pkg::OP_ERASE, rlt_pkg::OP_EXISTS: begin
            rsp_hit_in = any_hit;
         end
         rlt_pkg::OP_POSITION: begin
            rsp_hit_in = any_hit;
            rsp_pos_in = any_hit ? rank_ext[PW-1:0] : rlt_pkg::POS_ABSENT;
         end
         default: begin
            rsp_hit_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_data_ff <= rsp_data_in;
         rsp_pos_ff  <= rsp_pos_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_found_id   = rsp_id_ff;
   assign rsp_found_data = rsp_data_ff;
   assign rsp_position   = $signed(rsp_pos_ff);

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `RLT_ASSERT_ALWAYS(a_count_matches_valid, clock, reset, ($countones(slot_valid_ff) == int'(count_ff)), "entry count disagrees with valid slots")
   `RLT_ASSERT_ALWAYS(a_count_bounded, clock, reset, (count_ff <= COUNT_FULL), "entry count exceeds capacity")
   `RLT_ASSERT_NEXT(a_save_not_empty, clock, reset, (fire && (s1_op_ff == rlt_pkg::OP_SAVE)), (count_ff != '0), "table empty after a save")
   `RLT_ASSERT_NEXT(a_erase_shrinks, clock, reset, (fire && (s1_op_ff == rlt_pkg::OP_ERASE) && any_hit), (count_ff == $past(count_ff) - CW'(1)), "erase hit did not remove an entry")

endmodule
